/* hw/rtl/sparse_triplet_matrix_add_defines.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the sparse triplet matrix adder
// Concurrent checks with a synchronous active-low reset.
// ---------------------------------------------------------------------------
`ifndef SPARSE_TRIPLET_MATRIX_ADD_DEFINES_SVH
`define SPARSE_TRIPLET_MATRIX_ADD_DEFINES_SVH

// Overlapping implication: cons must hold in the cycle of ante.
`define STMA_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication: cons must hold in the cycle after ante.
`define STMA_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/stma_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Sparse triplet matrix adder package
// Shared types, input codes and back-end states.
// ---------------------------------------------------------------------------
package stma_pkg;

    localparam logic [1:0] KIND_LOAD_A = 2'd0;
    localparam logic [1:0] KIND_LOAD_B = 2'd1;
    localparam logic [1:0] KIND_RUN    = 2'd2;

    typedef enum logic [1:0] {
        OP_LOAD_A,
        OP_LOAD_B,
        OP_RUN
    } t_op;

    typedef struct packed {
        logic        [15:0] row;
        logic        [15:0] col;
        logic signed [15:0] value;
    } t_term;

    typedef struct packed {
        t_op   op;
        t_term term;
    } t_cmd;

    typedef struct packed {
        logic [1:0] level;
    } t_front_status;

    typedef struct packed {
        logic busy;
        logic overflow;
        logic full_a;
        logic full_b;
    } t_back_status;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CNT_FETCH,
        ST_CNT_STEP,
        ST_EMPTY,
        ST_EMIT_FETCH,
        ST_EMIT_STEP
    } t_back_state;

endpackage

/* hw/rtl/stma_if.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Sparse triplet matrix adder channels
// Valid/ready interfaces for the input items and the merged results.
// ---------------------------------------------------------------------------
interface stma_in_if;
    logic               valid;
    logic               ready;
    logic        [1:0]  kind;
    logic        [15:0] row;
    logic        [15:0] col;
    logic signed [15:0] value;

    modport source(output valid, output kind, output row, output col, output value,
                   input ready);
    modport sink(input valid, input kind, input row, input col, input value,
                 output ready);
endinterface

interface stma_out_if;
    logic               valid;
    logic               ready;
    logic        [15:0] out_row;
    logic        [15:0] out_col;
    logic signed [16:0] out_value;
    logic        [6:0]  total_terms;
    logic               empty_res;
    logic               overflow;
    logic               last;

    modport source(output valid, output out_row, output out_col, output out_value,
                   output total_terms, output empty_res, output overflow, output last,
                   input ready);
    modport sink(input valid, input out_row, input out_col, input out_value,
                 input total_terms, input empty_res, input overflow, input last,
                 output ready);
endinterface

/* hw/rtl/sparse_triplet_matrix_add.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Sparse triplet matrix adder
// Merges two sorted (row, col, value) lists, summing terms on equal positions.
// ---------------------------------------------------------------------------
// Usage:
//   i_in carries one transaction per item: kind 0 appends a term to the first
//   list, kind 1 to the second, kind 2 runs the merge, kind 3 is dropped.
//   Loads are taken one per cycle while the two-entry command queue has room,
//   and are stored in a term store when the back end takes them from it.
//   A run walks the lists twice: a counting pass, then an emit pass that puts
//   one result per merged term on o_out, each carrying the total count.
//   Each pass spends a fetch state and a step state on every merged term, as
//   the single read port of each term store is registered. An empty merge
//   gives one result with empty_res and last set.
//   A full list drops further loads and sets the sticky overflow flag.
//   Reset empties both lists and clears overflow; store contents stay as is.
//   When the receiver stalls, the result holds in the output register and
//   the merge waits; input items keep queuing until the queue fills.
// ---------------------------------------------------------------------------
`include "sparse_triplet_matrix_add_defines.svh"

module sparse_triplet_matrix_add #(
    parameter int MAX_TERMS = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    stma_in_if.sink    i_in,
    stma_out_if.source o_out
);

    logic                    cmd_valid;
    logic                    cmd_ready;
    stma_pkg::t_cmd          cmd;
    stma_pkg::t_front_status front_st;
    stma_pkg::t_back_status  back_st;

    stma_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_ready (cmd_ready),
        .o_status    (front_st)
    );

    stma_back #(
        .MAX_TERMS (MAX_TERMS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_ready (cmd_ready),
        .o_out       (o_out),
        .o_status    (back_st)
    );

    `STMA_ASSERT_NXT(a_ovf_sticky, i_clk, i_rst_n, back_st.overflow, back_st.overflow, "overflow flag cleared without reset")
    `STMA_ASSERT_NXT(a_full_a_holds, i_clk, i_rst_n, back_st.full_a, back_st.full_a, "first list count dropped from full")
    `STMA_ASSERT_NXT(a_full_b_holds, i_clk, i_rst_n, back_st.full_b, back_st.full_b, "second list count dropped from full")
    `STMA_ASSERT_IMP(a_queue_ready, i_clk, i_rst_n, i_in.ready, front_st.level != 2'd2, "ready while command queue full")
    `STMA_ASSERT_IMP(a_queue_drains, i_clk, i_rst_n, back_st.busy, !cmd_ready, "back end takes commands while merging")

endmodule

/* hw/rtl/stma_front.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Sparse triplet matrix adder front end
// Accepts input transactions, decodes the kind and queues commands.
// ---------------------------------------------------------------------------
module stma_front (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    stma_in_if.sink                i_in,
    output logic                   o_cmd_valid,
    output stma_pkg::t_cmd         o_cmd,
    input  logic                   i_cmd_ready,
    output stma_pkg::t_front_status o_status
);

    stma_pkg::t_cmd r_q [2];
    logic           r_wr_ptr;
    logic           r_rd_ptr;
    logic [1:0]     r_level;

    logic           in_accept;
    logic           push;
    logic           pop;
    stma_pkg::t_cmd in_cmd;
    logic           in_known;

    always_comb begin
        in_cmd.term.row   = i_in.row;
        in_cmd.term.col   = i_in.col;
        in_cmd.term.value = i_in.value;
        in_known          = 1'b1;
        unique case (i_in.kind)
            stma_pkg::KIND_LOAD_A: in_cmd.op = stma_pkg::OP_LOAD_A;
            stma_pkg::KIND_LOAD_B: in_cmd.op = stma_pkg::OP_LOAD_B;
            stma_pkg::KIND_RUN:    in_cmd.op = stma_pkg::OP_RUN;
            default: begin
                // drop unused codes
                in_cmd.op = stma_pkg::OP_RUN;
                in_known  = 1'b0;
            end
        endcase
    end

    assign i_in.ready  = (r_level != 2'd2);
    assign in_accept   = i_in.valid && i_in.ready;
    assign push        = in_accept && in_known;
    assign o_cmd_valid = (r_level != 2'd0);
    assign o_cmd       = r_q[r_rd_ptr];
    assign pop         = o_cmd_valid && i_cmd_ready;
    assign o_status.level = r_level;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_level  <= 2'd0;
        end else begin
            if (push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({push, pop})
                2'b10:   r_level <= r_level + 2'd1;
                2'b01:   r_level <= r_level - 2'd1;
                default: r_level <= r_level;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= in_cmd;
        end
    end

endmodule

/* hw/rtl/stma_back.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Sparse triplet matrix adder back end
// Term stores, two-pass merge walk and the result output register.
// ---------------------------------------------------------------------------
module stma_back #(
    parameter int MAX_TERMS = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cmd_valid,
    input  stma_pkg::t_cmd         i_cmd,
    output logic                   o_cmd_ready,
    stma_out_if.source             o_out,
    output stma_pkg::t_back_status o_status
);

    localparam int IW = $clog2(MAX_TERMS + 1);
    localparam int AW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
    localparam int KW = $clog2(2 * MAX_TERMS + 1);

    stma_pkg::t_term mem_a [MAX_TERMS];
    stma_pkg::t_term mem_b [MAX_TERMS];
    stma_pkg::t_term r_rd_a;
    stma_pkg::t_term r_rd_b;

    stma_pkg::t_back_state r_state, n_state;

    logic [IW-1:0] r_cnt_a, n_cnt_a;
    logic [IW-1:0] r_cnt_b, n_cnt_b;
    logic          r_overflow, n_overflow;
    logic [IW-1:0] r_i, n_i;
    logic [IW-1:0] r_j, n_j;
    logic [KW-1:0] r_k, n_k;

    logic               r_ov;
    logic               n_ov;
    logic        [15:0] r_o_row, n_o_row;
    logic        [15:0] r_o_col, n_o_col;
    logic signed [16:0] r_o_value, n_o_value;
    logic        [6:0]  r_o_total, n_o_total;
    logic               r_o_empty, n_o_empty;
    logic               r_o_ovf, n_o_ovf;
    logic               r_o_last, n_o_last;

    logic               cmd_take;
    logic               wr_a;
    logic               wr_b;
    logic               full_a;
    logic               full_b;
    logic               out_free;
    logic               a_ok;
    logic               b_ok;
    logic               same_pos;
    logic               a_first;
    logic               adv_a;
    logic               adv_b;
    logic               have_term;
    logic        [15:0] t_row;
    logic        [15:0] t_col;
    logic signed [16:0] t_value;
    logic [IW-1:0]      i_adv;
    logic [IW-1:0]      j_adv;
    logic               t_last;

    assign full_a      = (r_cnt_a == IW'(MAX_TERMS));
    assign full_b      = (r_cnt_b == IW'(MAX_TERMS));
    assign o_cmd_ready = (r_state == stma_pkg::ST_IDLE);
    assign cmd_take    = i_cmd_valid && o_cmd_ready;
    assign wr_a        = cmd_take && (i_cmd.op == stma_pkg::OP_LOAD_A) && !full_a;
    assign wr_b        = cmd_take && (i_cmd.op == stma_pkg::OP_LOAD_B) && !full_b;
    assign out_free    = !r_ov || o_out.ready;

    // Merge step on the fetched heads of both lists
    always_comb begin
        a_ok     = (r_i < r_cnt_a);
        b_ok     = (r_j < r_cnt_b);
        same_pos = (r_rd_a.row == r_rd_b.row) && (r_rd_a.col == r_rd_b.col);
        a_first  = (r_rd_a.row < r_rd_b.row)
                || ((r_rd_a.row == r_rd_b.row) && (r_rd_a.col < r_rd_b.col));
        adv_a    = 1'b0;
        adv_b    = 1'b0;
        t_row    = r_rd_a.row;
        t_col    = r_rd_a.col;
        t_value  = {r_rd_a.value[15], r_rd_a.value};
        if (a_ok && b_ok) begin
            if (same_pos) begin
                adv_a   = 1'b1;
                adv_b   = 1'b1;
                t_value = {r_rd_a.value[15], r_rd_a.value}
                        + {r_rd_b.value[15], r_rd_b.value};
            end else if (a_first) begin
                adv_a = 1'b1;
            end else begin
                adv_b   = 1'b1;
                t_row   = r_rd_b.row;
                t_col   = r_rd_b.col;
                t_value = {r_rd_b.value[15], r_rd_b.value};
            end
        end else if (a_ok) begin
            adv_a = 1'b1;
        end else if (b_ok) begin
            adv_b   = 1'b1;
            t_row   = r_rd_b.row;
            t_col   = r_rd_b.col;
            t_value = {r_rd_b.value[15], r_rd_b.value};
        end
        have_term = a_ok || b_ok;
        i_adv     = r_i + IW'(adv_a);
        j_adv     = r_j + IW'(adv_b);
        t_last    = (i_adv >= r_cnt_a) && (j_adv >= r_cnt_b);
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            stma_pkg::ST_IDLE: begin
                if (cmd_take && (i_cmd.op == stma_pkg::OP_RUN)) begin
                    n_state = stma_pkg::ST_CNT_FETCH;
                end
            end
            stma_pkg::ST_CNT_FETCH: n_state = stma_pkg::ST_CNT_STEP;
            stma_pkg::ST_CNT_STEP: begin
                if (have_term) begin
                    n_state = stma_pkg::ST_CNT_FETCH;
                end else if (r_k == '0) begin
                    n_state = stma_pkg::ST_EMPTY;
                end else begin
                    n_state = stma_pkg::ST_EMIT_FETCH;
                end
            end
            stma_pkg::ST_EMPTY: begin
                if (out_free) begin
                    n_state = stma_pkg::ST_IDLE;
                end
            end
            stma_pkg::ST_EMIT_FETCH: n_state = stma_pkg::ST_EMIT_STEP;
            stma_pkg::ST_EMIT_STEP: begin
                if (out_free) begin
                    n_state = t_last ? stma_pkg::ST_IDLE : stma_pkg::ST_EMIT_FETCH;
                end
            end
            default: n_state = stma_pkg::ST_IDLE;
        endcase
    end

    // Datapath and output register updates
    always_comb begin
        n_cnt_a    = r_cnt_a;
        n_cnt_b    = r_cnt_b;
        n_overflow = r_overflow;
        n_i        = r_i;
        n_j        = r_j;
        n_k        = r_k;
        n_ov       = r_ov && !o_out.ready;
        n_o_row    = r_o_row;
        n_o_col    = r_o_col;
        n_o_value  = r_o_value;
        n_o_total  = r_o_total;
        n_o_empty  = r_o_empty;
        n_o_ovf    = r_o_ovf;
        n_o_last   = r_o_last;
        unique case (r_state)
            stma_pkg::ST_IDLE: begin
                if (cmd_take) begin
                    case (i_cmd.op)
                        stma_pkg::OP_LOAD_A: begin
                            if (full_a) n_overflow = 1'b1;
                            else        n_cnt_a    = r_cnt_a + IW'(1);
                        end
                        stma_pkg::OP_LOAD_B: begin
                            if (full_b) n_overflow = 1'b1;
                            else        n_cnt_b    = r_cnt_b + IW'(1);
                        end
                        default: begin
                            n_i = '0;
                            n_j = '0;
                            n_k = '0;
                        end
                    endcase
                end
            end
            stma_pkg::ST_CNT_FETCH: begin
            end
            stma_pkg::ST_CNT_STEP: begin
                if (have_term) begin
                    n_i = i_adv;
                    n_j = j_adv;
                    n_k = r_k + KW'(1);
                end else begin
                    // rewind for the emit pass
                    n_i = '0;
                    n_j = '0;
                end
            end
            stma_pkg::ST_EMPTY: begin
                if (out_free) begin
                    n_ov      = 1'b1;
                    n_o_row   = '0;
                    n_o_col   = '0;
                    n_o_value = '0;
                    n_o_total = '0;
                    n_o_empty = 1'b1;
                    n_o_ovf   = r_overflow;
                    n_o_last  = 1'b1;
                end
            end
            stma_pkg::ST_EMIT_FETCH: begin
            end
            stma_pkg::ST_EMIT_STEP: begin
                if (out_free) begin
                    n_i       = i_adv;
                    n_j       = j_adv;
                    n_ov      = 1'b1;
                    n_o_row   = t_row;
                    n_o_col   = t_col;
                    n_o_value = t_value;
                    n_o_total = 7'(r_k);
                    n_o_empty = 1'b0;
                    n_o_ovf   = r_overflow;
                    n_o_last  = t_last;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= stma_pkg::ST_IDLE;
            r_cnt_a    <= '0;
            r_cnt_b    <= '0;
            r_overflow <= 1'b0;
            r_i        <= '0;
            r_j        <= '0;
            r_k        <= '0;
            r_ov       <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_cnt_a    <= n_cnt_a;
            r_cnt_b    <= n_cnt_b;
            r_overflow <= n_overflow;
            r_i        <= n_i;
            r_j        <= n_j;
            r_k        <= n_k;
            r_ov       <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_o_row   <= n_o_row;
        r_o_col   <= n_o_col;
        r_o_value <= n_o_value;
        r_o_total <= n_o_total;
        r_o_empty <= n_o_empty;
        r_o_ovf   <= n_o_ovf;
        r_o_last  <= n_o_last;
    end

    // Term stores: one write port, one registered read port each
    always_ff @(posedge i_clk) begin
        if (wr_a) begin
            mem_a[r_cnt_a[AW-1:0]] <= i_cmd.term;
        end
        r_rd_a <= mem_a[r_i[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (wr_b) begin
            mem_b[r_cnt_b[AW-1:0]] <= i_cmd.term;
        end
        r_rd_b <= mem_b[r_j[AW-1:0]];
    end

    assign o_out.valid       = r_ov;
    assign o_out.out_row     = r_o_row;
    assign o_out.out_col     = r_o_col;
    assign o_out.out_value   = r_o_value;
    assign o_out.total_terms = r_o_total;
    assign o_out.empty_res   = r_o_empty;
    assign o_out.overflow    = r_o_ovf;
    assign o_out.last        = r_o_last;

    assign o_status.busy     = (r_state != stma_pkg::ST_IDLE);
    assign o_status.overflow = r_overflow;
    assign o_status.full_a   = full_a;
    assign o_status.full_b   = full_b;

endmodule

/* tb/sv/sparse_triplet_matrix_add_checker.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Sparse triplet matrix adder checker
// Watches the input and result channels, keeps its own copy of both term
// lists and the sticky overflow flag, and on every run transaction computes
// the merged list. Each result transaction is compared field by field with
// the oldest merged term still waiting.
// ---------------------------------------------------------------------------
module sparse_triplet_matrix_add_checker #(
    parameter int MAX_TERMS = 32
) (
    input  logic i_clk,
    input  logic i_rst_n,
    stma_in_if   i_in_mon,
    stma_out_if  i_out_mon,
    output int   o_fail_count,
    output int   o_pending
);

    localparam int MAX_REPORTS = 100;

    typedef struct {
        logic        [15:0] row;
        logic        [15:0] col;
        logic signed [16:0] value;
        logic        [6:0]  total;
        logic               empty;
        logic               overflow;
        logic               last;
    } t_merged_term;

    stma_pkg::t_term list_a [MAX_TERMS];
    stma_pkg::t_term list_b [MAX_TERMS];
    int              count_a = 0;
    int              count_b = 0;
    logic            dropped = 1'b0;
    t_merged_term    merged_q [$];
    int              fail_count = 0;
    int              report_count = 0;

    function automatic void note_failure(string what);
        fail_count++;
        if (report_count < MAX_REPORTS) begin
            report_count++;
            $display("%0t ns: %s", $time, what);
        end
    endfunction

    function automatic void check_field(string name, logic [16:0] want, logic [16:0] got);
        if (got !== want)
            note_failure($sformatf("%s expected %h, got %h", name, want, got));
    endfunction

    function automatic logic signed [16:0] widen(logic signed [15:0] v);
        return {v[15], v};
    endfunction

    task automatic store_term(input logic to_b, input stma_pkg::t_term t);
        if (to_b) begin
            if (count_b >= MAX_TERMS) begin
                dropped = 1'b1;
            end else begin
                list_b[count_b] = t;
                count_b++;
            end
        end else begin
            if (count_a >= MAX_TERMS) begin
                dropped = 1'b1;
            end else begin
                list_a[count_a] = t;
                count_a++;
            end
        end
    endtask

    // Walk both lists by comparing heads; equal coordinates fold into one term.
    task automatic merge_lists();
        t_merged_term run_q [$];
        t_merged_term m;
        int           i;
        int           j;
        int           n;
        i = 0;
        j = 0;
        m.total    = '0;
        m.empty    = 1'b0;
        m.overflow = dropped;
        m.last     = 1'b0;
        while (i < count_a || j < count_b) begin
            if (i < count_a && j < count_b &&
                {list_a[i].row, list_a[i].col} == {list_b[j].row, list_b[j].col}) begin
                m.row   = list_a[i].row;
                m.col   = list_a[i].col;
                m.value = widen(list_a[i].value) + widen(list_b[j].value);
                i++;
                j++;
            end else if (j >= count_b ||
                         (i < count_a &&
                          {list_a[i].row, list_a[i].col} < {list_b[j].row, list_b[j].col})) begin
                m.row   = list_a[i].row;
                m.col   = list_a[i].col;
                m.value = widen(list_a[i].value);
                i++;
            end else begin
                m.row   = list_b[j].row;
                m.col   = list_b[j].col;
                m.value = widen(list_b[j].value);
                j++;
            end
            run_q.push_back(m);
        end
        n = run_q.size();
        if (n == 0) begin
            m.row   = '0;
            m.col   = '0;
            m.value = '0;
            m.empty = 1'b1;
            m.last  = 1'b1;
            merged_q.push_back(m);
        end else begin
            for (int x = 0; x < n; x++) begin
                m       = run_q[x];
                m.total = 7'(n);
                m.last  = (x == n - 1);
                merged_q.push_back(m);
            end
        end
    endtask

    always @(posedge i_clk) begin
        stma_pkg::t_term t;
        t_merged_term    want;
        if (!i_rst_n) begin
            count_a = 0;
            count_b = 0;
            dropped = 1'b0;
            merged_q.delete();
        end else begin
            if (i_in_mon.valid && i_in_mon.ready) begin
                t.row   = i_in_mon.row;
                t.col   = i_in_mon.col;
                t.value = i_in_mon.value;
                case (i_in_mon.kind)
                    stma_pkg::KIND_LOAD_A: store_term(1'b0, t);
                    stma_pkg::KIND_LOAD_B: store_term(1'b1, t);
                    stma_pkg::KIND_RUN:    merge_lists();
                    default: ;
                endcase
            end
            if (i_out_mon.valid && i_out_mon.ready) begin
                if (merged_q.size() == 0) begin
                    note_failure($sformatf("result with none waiting: row %h col %h value %h",
                                           i_out_mon.out_row, i_out_mon.out_col,
                                           i_out_mon.out_value));
                end else begin
                    want = merged_q.pop_front();
                    check_field("out_row", 17'(want.row), 17'(i_out_mon.out_row));
                    check_field("out_col", 17'(want.col), 17'(i_out_mon.out_col));
                    check_field("out_value", want.value, i_out_mon.out_value);
                    check_field("total_terms", 17'(want.total), 17'(i_out_mon.total_terms));
                    check_field("empty_res", 17'(want.empty), 17'(i_out_mon.empty_res));
                    check_field("overflow", 17'(want.overflow), 17'(i_out_mon.overflow));
                    check_field("last", 17'(want.last), 17'(i_out_mon.last));
                end
            end
        end
        o_fail_count = fail_count;
        o_pending    = merged_q.size();
    end

endmodule

/* tb/sv/sparse_triplet_matrix_add_tb.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Sparse triplet matrix adder testbench
// Drives directed loads and runs covering extreme values, summed and zero
// terms, out-of-order terms and the empty merge, then random traffic made
// mostly of sorted term sequences under several idle and stall patterns,
// including one long result stall. The checker does the comparison.
// ---------------------------------------------------------------------------
module sparse_triplet_matrix_add_tb;

    localparam int         MAX_TERMS    = 32;
    localparam int         NUM_RANDOM   = 300;
    localparam int         HOLD_CYCLES  = 400;
    localparam int         DRAIN_CYCLES = 300;
    localparam int         STALL_LIMIT  = 5000;
    localparam logic [1:0] KIND_UNUSED  = 2'd3;

    logic        clk;
    logic        rst_n;
    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;
    logic        hold_req       = 1'b0;
    logic        hold_done      = 1'b0;
    int          fail_count;
    int          pending;
    int          quiet_cycles   = 0;
    int          loads_a        = 0;
    int          loads_b        = 0;
    int          useful         = 0;
    logic [31:0] last_key_a;
    logic [31:0] last_key_b;

    stma_in_if  in_ch ();
    stma_out_if out_ch ();

    sparse_triplet_matrix_add #(
        .MAX_TERMS(MAX_TERMS)
    ) u_dut (
        .i_clk  (clk),
        .i_rst_n(rst_n),
        .i_in   (in_ch),
        .o_out  (out_ch)
    );

    sparse_triplet_matrix_add_checker #(
        .MAX_TERMS(MAX_TERMS)
    ) u_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_mon    (in_ch),
        .i_out_mon   (out_ch),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    always begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // Result side: random stalls, plus one long hold-off on request.
    initial begin
        out_ch.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_req && !hold_done) begin
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
                hold_done = 1'b1;
            end else begin
                out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == STALL_LIMIT) begin
            $display("sparse_triplet_matrix_add: mismatch");
            $finish;
        end
    end

    task automatic send_item(input logic [1:0] kind, input logic [15:0] row,
                             input logic [15:0] col, input logic [15:0] value);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(negedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.kind  <= kind;
        in_ch.row   <= row;
        in_ch.col   <= col;
        in_ch.value <= value;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic load_term(input logic to_b, input logic [15:0] row,
                             input logic [15:0] col, input logic [15:0] value);
        if (to_b) begin
            if (loads_b < MAX_TERMS) useful++;
            loads_b++;
            send_item(stma_pkg::KIND_LOAD_B, row, col, value);
        end else begin
            if (loads_a < MAX_TERMS) useful++;
            loads_a++;
            send_item(stma_pkg::KIND_LOAD_A, row, col, value);
        end
    endtask

    task automatic send_run();
        useful++;
        send_item(stma_pkg::KIND_RUN, 16'($urandom), 16'($urandom), 16'($urandom));
    endtask

    // Mostly extend the sorted sequence, often landing on the other list's
    // latest coordinate; sometimes drop a term anywhere.
    task automatic send_load(input logic to_b);
        logic [31:0] key;
        logic [31:0] mine;
        logic [31:0] other;
        logic [15:0] value;
        int          roll;
        mine  = to_b ? last_key_b : last_key_a;
        other = to_b ? last_key_a : last_key_b;
        roll  = $urandom_range(99);
        if (roll < 15)
            key = $urandom;
        else if (other > mine && roll < 55)
            key = other;
        else
            key = (mine > other ? mine : other) +
                  $urandom_range(1, 1 << $urandom_range(0, 26));
        if ($urandom_range(9) == 0)
            value = $urandom_range(1) ? 16'h7fff : 16'h8000;
        else
            value = 16'($urandom);
        if (roll >= 15) begin
            if (to_b) last_key_b = key;
            else      last_key_a = key;
        end
        load_term(to_b, key[31:16], key[15:0], value);
    endtask

    task automatic send_random_item();
        int pa;
        int pb;
        int roll;
        pa   = (loads_a < MAX_TERMS) ? 22 : 3;
        pb   = (loads_b < MAX_TERMS) ? 22 : 3;
        roll = $urandom_range(99);
        if (roll < pa)
            send_load(1'b0);
        else if (roll < pa + pb)
            send_load(1'b1);
        else if (roll < pa + pb + 5)
            send_item(KIND_UNUSED, 16'($urandom), 16'($urandom), 16'($urandom));
        else
            send_run();
    endtask

    initial begin
        rst_n       = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.kind  = stma_pkg::KIND_LOAD_A;
        in_ch.row   = '0;
        in_ch.col   = '0;
        in_ch.value = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Empty merge, unused kind, empty merge again.
        send_run();
        send_item(KIND_UNUSED, 16'hffff, 16'hffff, 16'hffff);
        send_run();
        // Equal coordinates: most negative sum, most positive sum, zero sum.
        load_term(1'b0, 16'd0, 16'd0, 16'h8000);
        load_term(1'b1, 16'd0, 16'd0, 16'h8000);
        load_term(1'b0, 16'd0, 16'd1, 16'h7fff);
        load_term(1'b1, 16'd0, 16'd1, 16'h7fff);
        load_term(1'b0, 16'd0, 16'd2, 16'd5);
        load_term(1'b1, 16'd0, 16'd2, -16'sd5);
        // Lower row with a higher column must come first.
        load_term(1'b1, 16'd0, 16'd3, 16'd1);
        load_term(1'b0, 16'd1, 16'd0, 16'd7);
        send_run();
        // Same row, columns decide; then a zero sum after a single term.
        load_term(1'b0, 16'd1, 16'd5, 16'hffff);
        load_term(1'b1, 16'd1, 16'd4, 16'h7fff);
        load_term(1'b1, 16'd1, 16'd5, 16'd1);
        send_run();
        // Largest coordinates in both lists, then a term out of order.
        load_term(1'b0, 16'hffff, 16'hffff, 16'h8000);
        load_term(1'b1, 16'hffff, 16'hffff, 16'hffff);
        send_run();
        load_term(1'b0, 16'd0, 16'd9, 16'd3);
        send_run();
        send_item(KIND_UNUSED, 16'd0, 16'd0, 16'd0);

        last_key_a = {16'd1, 16'd5};
        last_key_b = {16'd1, 16'd5};
        useful     = 0;
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 63; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 63; end
                default: begin send_idle_pct = 35; recv_stall_pct = 35; end
            endcase
            if (phase == 2) begin
                // Hold results off while items keep coming, so the block backs up.
                send_idle_pct = 0;
                hold_req      = 1'b1;
                send_run();
                repeat (12) send_random_item();
            end
            while (useful < (phase + 1) * NUM_RANDOM / 4) send_random_item();
        end

        in_ch.valid <= 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("sparse_triplet_matrix_add: match");
        else
            $display("sparse_triplet_matrix_add: mismatch");
        $finish;
    end

endmodule
